// ===== rtl/lsgp_pkg.sv =====
// Shared types, constants and helpers of the linkage score greedy pruner.
package lsgp_pkg;

  // Number of variants held in the keep bitmap.
  localparam int unsigned NUM_VARIANTS = 65536;
  localparam int unsigned KEEP_AW      = $clog2(NUM_VARIANTS);

  // Field widths.
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned CORR_W  = 16;
  localparam int unsigned MAG_W   = 16;
  localparam int unsigned SQ_W    = 2 * MAG_W;
  localparam int unsigned LIMIT_W = 47;
  localparam int unsigned SUM_W   = 48;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Command codes on the input channel.
  localparam logic [1:0] CMD_SET_KEEP = 2'd0;
  localparam logic [1:0] CMD_ENTRY    = 2'd1;
  localparam logic [1:0] CMD_EMPTY    = 2'd2;

  typedef enum logic [1:0] {
    OP_SET_KEEP,
    OP_ENTRY,
    OP_EMPTY
  } lsgp_op_e;

  // Input beat.
  typedef struct packed {
    logic [1:0]               cmd;
    logic [IDX_W-1:0]         column_index;
    logic [IDX_W-1:0]         row_index;
    logic signed [CORR_W-1:0] corr_value;
    logic [LIMIT_W-1:0]       score_limit;
    logic                     first_of_column;
    logic                     last_of_column;
    logic                     keep_value;
  } lsgp_in_t;

  // Result beat.
  typedef struct packed {
    logic [IDX_W-1:0] column_index_res;
    logic             kept;
  } lsgp_out_t;

  // Classified operation held in the queue.
  typedef struct packed {
    lsgp_op_e           op;
    logic [IDX_W-1:0]   column_index;
    logic [IDX_W-1:0]   row_index;
    logic [MAG_W-1:0]   mag;
    logic [LIMIT_W-1:0] score_limit;
    logic               first;
    logic               last;
    logic               keep_value;
    logic               col_ok;
    logic               row_ok;
  } lsgp_op_t;

  // Queue status seen by the front, the back and the top level.
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } lsgp_q_stat_t;

  // Back status seen by the front and the top level.
  typedef struct packed {
    logic clearing;
    logic s1_valid;
  } lsgp_back_stat_t;

  // True when the index addresses a real bitmap entry.
  function automatic logic idx_ok(logic [IDX_W-1:0] idx);
    return 32'(idx) < NUM_VARIANTS;
  endfunction

  // Bitmap address of an index.
  function automatic logic [KEEP_AW-1:0] keep_addr(logic [IDX_W-1:0] idx);
    return KEEP_AW'(idx);
  endfunction

endpackage

// ===== rtl/ld_score_greedy_pruner_top.sv =====
// Top level of the linkage score greedy pruner: front, queue and back.
//
// The block takes one beat per clock cycle while the result side keeps up, and returns a
// column's decision once its last entry or empty-column beat has passed the queue and the
// execute stage. Every queued beat makes one pass through a single execute stage, in which
// the 48-bit saturating add and the compare against the column limit form the loop that
// sets the clock; the keep bitmap is read on two ports as a beat leaves the queue, and a
// write from the beat ahead is forwarded. After reset the bitmap is cleared one entry per
// cycle, all NUM_VARIANTS (65536) entries, and in_ready_o stays low until the pass is done.
module ld_score_greedy_pruner_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lsgp_pkg::lsgp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lsgp_pkg::lsgp_out_t out_data_o
);
  import lsgp_pkg::*;

  logic            push, pop;
  lsgp_op_t        push_op, head_op;
  lsgp_q_stat_t    q_stat;
  lsgp_back_stat_t back_stat;

  lsgp_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_stat_i    (q_stat),
    .back_stat_i (back_stat),
    .push_o      (push),
    .push_op_o   (push_op)
  );

  lsgp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .head_op_o (head_op),
    .stat_o    (q_stat)
  );

  lsgp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_op_i   (head_op),
    .pop_o       (pop),
    .stat_o      (back_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // Nothing is in flight while the bitmap is being cleared.
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.clearing |-> (!back_stat.s1_valid && q_stat.empty))
    else $error("operation in flight during the clearing pass");

  // A taken column entry is waiting in the queue on the next cycle.
  a_entry_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.cmd == CMD_ENTRY)) |=> !q_stat.empty)
    else $error("column entry beat lost between front and queue");

  // A new result only appears after an operation sat in the execute stage.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(back_stat.s1_valid))
    else $error("result raised without an executed operation");
`endif

endmodule

// ===== rtl/lsgp_front.sv =====
// Front part: accepts input beats, decodes the command and forms the queue entry.
module lsgp_front (
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  lsgp_pkg::lsgp_in_t       in_data_i,
  input  lsgp_pkg::lsgp_q_stat_t   q_stat_i,
  input  lsgp_pkg::lsgp_back_stat_t back_stat_i,
  output logic                     push_o,
  output lsgp_pkg::lsgp_op_t       push_op_o
);
  import lsgp_pkg::*;

  logic cmd_ok;

  // Beats are taken while the queue has room and the bitmap is not being cleared.
  assign in_ready_o = !q_stat_i.full && !back_stat_i.clearing;

  // Decode the command, fold the correlation to its magnitude and check the indexes.
  always_comb begin
    cmd_ok                    = 1'b1;
    push_op_o.op              = OP_ENTRY;
    push_op_o.column_index    = in_data_i.column_index;
    push_op_o.row_index       = in_data_i.row_index;
    push_op_o.score_limit     = in_data_i.score_limit;
    push_op_o.first           = in_data_i.first_of_column;
    push_op_o.last            = in_data_i.last_of_column;
    push_op_o.keep_value      = in_data_i.keep_value;
    push_op_o.col_ok          = idx_ok(in_data_i.column_index);
    push_op_o.row_ok          = idx_ok(in_data_i.row_index);
    push_op_o.mag             = in_data_i.corr_value[CORR_W-1]
                                ? MAG_W'($unsigned(-in_data_i.corr_value))
                                : MAG_W'($unsigned(in_data_i.corr_value));
    case (in_data_i.cmd)
      CMD_SET_KEEP: begin
        push_op_o.op = OP_SET_KEEP;
      end
      CMD_ENTRY: begin
        push_op_o.op = OP_ENTRY;
      end
      CMD_EMPTY: begin
        push_op_o.op = OP_EMPTY;
      end
      default: begin
        // The unused command is taken and dropped.
        cmd_ok = 1'b0;
      end
    endcase
  end

  assign push_o = in_valid_i && in_ready_o && cmd_ok;

endmodule

// ===== rtl/lsgp_queue.sv =====
// Short queue of classified operations between the front and the back.
module lsgp_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  lsgp_pkg::lsgp_op_t     push_op_i,
  input  logic                   pop_i,
  output lsgp_pkg::lsgp_op_t     head_op_o,
  output lsgp_pkg::lsgp_q_stat_t stat_o
);
  import lsgp_pkg::*;

  lsgp_op_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] ptr);
    return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

  assign head_op_o    = entry_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule

// ===== rtl/lsgp_back.sv =====
// Back part: keep bitmap, squaring, score accumulation, pruning and the result register.
module lsgp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lsgp_pkg::lsgp_q_stat_t    q_stat_i,
  input  lsgp_pkg::lsgp_op_t        head_op_i,
  output logic                      pop_o,
  output lsgp_pkg::lsgp_back_stat_t stat_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output lsgp_pkg::lsgp_out_t       out_data_o
);
  import lsgp_pkg::*;

  // Keep bitmap and its registered read ports.
  logic               keep_mem_q [NUM_VARIANTS];
  logic               rd_row_q, rd_col_q;
  logic               mem_we;
  logic [KEEP_AW-1:0] mem_waddr;
  logic               mem_wdata;

  // Clearing pass after reset.
  logic               clr_busy_q;
  logic [KEEP_AW-1:0] clr_addr_q;

  // Execute stage.
  logic               s1_valid_q;
  lsgp_op_t           s1_op_q;
  logic [SQ_W-1:0]    sq_q;
  logic               fwd_row_hit_q, fwd_row_val_q;
  logic               fwd_col_hit_q, fwd_col_val_q;

  // Per-column running state.
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic               drop_q, drop_d;

  // Result register.
  logic               out_valid_q;
  lsgp_out_t          out_data_q;

  logic               advance;
  logic               s1_fire;
  logic               s1_we;
  logic [KEEP_AW-1:0] s1_waddr;
  logic               s1_wdata;
  logic               res_valid;
  lsgp_out_t          res;
  logic               keep_row, keep_col;
  logic               accumulate, prune;
  logic [SUM_W-1:0]   base_sum;
  logic               base_drop;
  logic [SUM_W:0]     sum_ext;
  logic [SUM_W-1:0]   sum_new;
  logic [KEEP_AW-1:0] head_row_addr, head_col_addr;
  logic [SQ_W-1:0]    sq;

  // The execute stage and the result register move on whenever the result register can take a beat.
  assign advance = !out_valid_q || out_ready_i;
  assign pop_o   = advance && !q_stat_i.empty && !clr_busy_q;
  assign s1_fire = s1_valid_q && advance;

  assign head_row_addr = keep_addr(head_op_i.row_index);
  assign head_col_addr = keep_addr(head_op_i.column_index);
  assign sq            = head_op_i.mag * head_op_i.mag;

  // Execute: write keep bits, accumulate the square, compare with the limit and decide.
  always_comb begin
    keep_row  = s1_op_q.row_ok & (fwd_row_hit_q ? fwd_row_val_q : rd_row_q);
    keep_col  = s1_op_q.col_ok & (fwd_col_hit_q ? fwd_col_val_q : rd_col_q);
    base_sum  = s1_op_q.first ? '0 : sum_q;
    base_drop = s1_op_q.first ? 1'b0 : drop_q;
    sum_ext   = {1'b0, base_sum} + (SUM_W + 1)'(sq_q);
    sum_new   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    accumulate = !base_drop && keep_row;
    prune     = accumulate && (sum_new > SUM_W'(s1_op_q.score_limit));

    sum_d     = sum_q;
    drop_d    = drop_q;
    s1_we     = 1'b0;
    s1_waddr  = keep_addr(s1_op_q.column_index);
    s1_wdata  = 1'b0;
    res_valid = 1'b0;
    res.column_index_res = s1_op_q.column_index;
    res.kept             = keep_col;

    case (s1_op_q.op)
      OP_SET_KEEP: begin
        s1_we    = s1_op_q.col_ok;
        s1_wdata = s1_op_q.keep_value;
      end
      OP_ENTRY: begin
        s1_we  = prune && s1_op_q.col_ok;
        sum_d  = accumulate ? sum_new : base_sum;
        drop_d = base_drop | prune;
        if (s1_op_q.last) begin
          res_valid = 1'b1;
          res.kept  = keep_col & ~prune;
          sum_d     = '0;
          drop_d    = 1'b0;
        end
      end
      OP_EMPTY: begin
        res_valid = 1'b1;
        sum_d     = '0;
        drop_d    = 1'b0;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    s1_we = s1_we && s1_fire;
  end

  // Write port shared by the clearing pass and the execute stage.
  assign mem_we    = clr_busy_q || s1_we;
  assign mem_waddr = clr_busy_q ? clr_addr_q : s1_waddr;
  assign mem_wdata = clr_busy_q ? 1'b0 : s1_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      keep_mem_q[mem_waddr] <= mem_wdata;
    end
  end

  // Reads are issued as an operation leaves the queue; a write in the same cycle is forwarded.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_row_q      <= keep_mem_q[head_row_addr];
      rd_col_q      <= keep_mem_q[head_col_addr];
      fwd_row_hit_q <= s1_we && (s1_waddr == head_row_addr);
      fwd_col_hit_q <= s1_we && (s1_waddr == head_col_addr);
      fwd_row_val_q <= s1_wdata;
      fwd_col_val_q <= s1_wdata;
      s1_op_q       <= head_op_i;
      sq_q          <= sq;
    end
  end

  // Control state, column state and the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      sum_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == KEEP_AW'(NUM_VARIANTS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (advance) begin
        s1_valid_q  <= pop_o;
        out_valid_q <= s1_valid_q && res_valid;
      end
      if (s1_fire) begin
        sum_q  <= sum_d;
        drop_q <= drop_d;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (s1_fire && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign stat_o.clearing = clr_busy_q;
  assign stat_o.s1_valid = s1_valid_q;

endmodule

// ===== bench/ld_score_greedy_pruner_top_test.sv =====
// Self-checking testbench of the linkage score greedy pruner top level.
module ld_score_greedy_pruner_top_test;
  import lsgp_pkg::*;

  // The command code that the block must ignore.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int ITEM_TARGET   = 1000;
  localparam int STALL_LIMIT   = 4 * NUM_VARIANTS;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 150;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
  localparam logic [LIMIT_W-1:0] ONE_Q30   = 47'd1 << 30;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  lsgp_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  lsgp_out_t out_data_o;

  // One row of the directed table: the beat and, where it is obvious, its decision.
  typedef struct {
    lsgp_in_t  beat;
    bit        typed;
    lsgp_out_t decision;
  } stim_row_t;

  // Shadow state of the pruner.
  bit               keep_bits [NUM_VARIANTS];
  logic [SUM_W-1:0] column_score  = '0;
  bit               column_pruned = 1'b0;

  lsgp_out_t decisions_due [$];
  stim_row_t directed_rows [$];
  int        mismatches  = 0;
  int        items_sent  = 0;
  bit        idle_en     = 1'b1;
  bit        hold_request = 1'b0;
  int        hold_left   = 0;

  ld_score_greedy_pruner_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic bit keep_of(input logic [IDX_W-1:0] idx);
    if (32'(idx) >= NUM_VARIANTS) return 1'b0;
    return keep_bits[idx];
  endfunction

  // Applies one beat to the shadow state and works out the decision it reports, if any.
  function automatic void prune_step(input lsgp_in_t beat, output bit has_res,
                                     output lsgp_out_t res);
    logic [MAG_W-1:0] mag;
    logic [SQ_W-1:0]  sq;
    logic [SUM_W:0]   total;
    has_res = 1'b0;
    res     = '0;
    case (beat.cmd)
      CMD_SET_KEEP: begin
        if (32'(beat.column_index) < NUM_VARIANTS)
          keep_bits[beat.column_index] = beat.keep_value;
      end
      CMD_EMPTY: begin
        column_score  = '0;
        column_pruned = 1'b0;
        has_res = 1'b1;
        res.column_index_res = beat.column_index;
        res.kept = keep_of(beat.column_index);
      end
      CMD_ENTRY: begin
        if (beat.first_of_column) begin
          column_score  = '0;
          column_pruned = 1'b0;
        end
        if (!column_pruned && keep_of(beat.row_index)) begin
          // The magnitude of -1.0 is 2^15, which still fits in 16 unsigned bits.
          mag   = beat.corr_value[CORR_W-1] ? (~beat.corr_value + 16'd1) : beat.corr_value;
          sq    = {16'd0, mag} * {16'd0, mag};
          total = {1'b0, column_score} + (SUM_W + 1)'(sq);
          column_score = total[SUM_W] ? '1 : total[SUM_W-1:0];
          if (column_score > {1'b0, beat.score_limit}) begin
            if (32'(beat.column_index) < NUM_VARIANTS) keep_bits[beat.column_index] = 1'b0;
            column_pruned = 1'b1;
          end
        end
        if (beat.last_of_column) begin
          has_res = 1'b1;
          res.column_index_res = beat.column_index;
          res.kept = keep_of(beat.column_index);
          column_score  = '0;
          column_pruned = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic lsgp_in_t beat_of(input logic [1:0] cmd, input logic [IDX_W-1:0] col,
                                       input logic [IDX_W-1:0] row,
                                       input logic [CORR_W-1:0] corr,
                                       input logic [LIMIT_W-1:0] limit,
                                       input bit first, input bit last, input bit keep);
    lsgp_in_t b;
    b.cmd             = cmd;
    b.column_index    = col;
    b.row_index       = row;
    b.corr_value      = corr;
    b.score_limit     = limit;
    b.first_of_column = first;
    b.last_of_column  = last;
    b.keep_value      = keep;
    return b;
  endfunction

  function automatic void add_row(input lsgp_in_t beat, input bit typed,
                                  input logic [IDX_W-1:0] col, input bit kept);
    stim_row_t r;
    r.beat = beat;
    r.typed = typed;
    r.decision.column_index_res = col;
    r.decision.kept = kept;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // Random beat with every field drawn over its full width.
  function automatic lsgp_in_t noise_beat();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[$bits(lsgp_in_t)-1:0];
  endfunction

  // Mostly a small pool of variants, so that keep bits set earlier are hit again.
  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [CORR_W-1:0] pick_corr();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom_range(0, 255)) ^ ($urandom_range(0, 1) ? 16'hFFFF : 16'h0);
      default: return 16'($urandom);
    endcase
  endfunction

  // Limits of a few units of 1.0 make pruning happen within a short column.
  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LIMIT_MAX;
      2:       return LIMIT_W'({$urandom, $urandom});
      default: return (LIMIT_W'($urandom_range(0, 3)) << 30)
                      | LIMIT_W'($urandom_range(0, 32'h3FFF_FFFF));
    endcase
  endfunction

  // Offers one beat, waits for it to be taken and records the decision it will cause.
  task automatic send_beat(input lsgp_in_t beat, input bit typed, input lsgp_out_t decision);
    bit        has_res;
    lsgp_out_t res;
    while (idle_en && $urandom_range(0, 99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    prune_step(beat, has_res, res);
    if (typed) decisions_due.insert(decisions_due.size(), decision);
    else if (has_res) decisions_due.insert(decisions_due.size(), res);
    if (beat.cmd != CMD_UNUSED) items_sent++;
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= !(idle_en && $urandom_range(0, 99) < 27);
      end
    end
  end

  // Each decision beat is compared with the oldest one outstanding.
  always @(posedge clk_i) begin
    lsgp_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decisions_due.size() == 0) begin
        report_mismatch($sformatf("unexpected decision for column %0d",
                                  out_data_o.column_index_res));
      end else begin
        want = decisions_due.pop_front();
        if (out_data_o.column_index_res !== want.column_index_res)
          report_mismatch($sformatf("column %0d, expected %0d",
                                    out_data_o.column_index_res, want.column_index_res));
        if (out_data_o.kept !== want.kept)
          report_mismatch($sformatf("column %0d kept %b, expected %b",
                                    want.column_index_res, out_data_o.kept, want.kept));
      end
    end
  end

  // Watchdog: ends the run after too long without any beat on either side.
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall = 0;
      else stall++;
    end
    $display("ld_score_greedy_pruner_top_test: errors");
    $finish;
  end

  // Main sequence: reset, directed table, then random columns.
  initial begin
    lsgp_in_t         beat;
    lsgp_out_t        none;
    logic [IDX_W-1:0] col;
    logic [LIMIT_W-1:0] limit;
    int               n_entries;
    bit               drop_first;
    bit               drop_last;
    bit               hold_done;
    bit               drain_done;
    none       = '0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;

    // After reset nothing is kept; then the corners of the index range.
    add_row(beat_of(CMD_EMPTY, 16'd0, 16'd0, 16'd0, '0, 0, 0, 0), 1, 16'd0, 0);
    add_row(beat_of(CMD_EMPTY, 16'hFFFF, 16'hFFFF, 16'hFFFF, LIMIT_MAX, 1, 1, 1), 1,
            16'hFFFF, 0);
    add_row(beat_of(CMD_SET_KEEP, 16'd0, 16'd0, 16'd0, '0, 0, 0, 1), 0, 16'd0, 0);
    add_row(beat_of(CMD_SET_KEEP, 16'hFFFF, 16'd0, 16'd0, '0, 0, 0, 1), 0, 16'd0, 0);
    add_row(beat_of(CMD_SET_KEEP, 16'd5, 16'hFFFF, 16'h8000, LIMIT_MAX, 1, 1, 1), 0, 16'd0, 0);
    add_row(beat_of(CMD_EMPTY, 16'd0, 16'd3, 16'd0, '0, 0, 0, 0), 1, 16'd0, 1);
    // The unused command must leave the keep bit and the column untouched.
    add_row(beat_of(CMD_UNUSED, 16'd5, 16'd5, 16'h7FFF, '0, 1, 1, 0), 0, 16'd0, 0);
    add_row(beat_of(CMD_EMPTY, 16'd5, 16'd0, 16'd0, '0, 0, 0, 0), 1, 16'd5, 1);
    // Minus one squared equals a limit of 1.0: not pruned until the next entry.
    add_row(beat_of(CMD_ENTRY, 16'd5, 16'd0, 16'h8000, ONE_Q30, 1, 0, 0), 0, 16'd0, 0);
    add_row(beat_of(CMD_ENTRY, 16'd5, 16'hFFFF, 16'h7FFF, ONE_Q30, 0, 1, 0), 0, 16'd0, 0);
    // A row that is no longer kept adds nothing.
    add_row(beat_of(CMD_ENTRY, 16'd0, 16'd5, 16'h7FFF, '0, 1, 1, 0), 0, 16'd0, 0);
    add_row(beat_of(CMD_ENTRY, 16'd0, 16'hFFFF, 16'd1, '0, 1, 1, 0), 0, 16'd0, 0);
    add_row(beat_of(CMD_SET_KEEP, 16'd0, 16'd0, 16'd0, '0, 0, 0, 1), 0, 16'd0, 0);
    // Zero correlation against a zero limit stays kept.
    add_row(beat_of(CMD_ENTRY, 16'hFFFF, 16'd0, 16'd0, '0, 1, 1, 0), 0, 16'd0, 0);
    // Once pruned, the rest of the column is ignored.
    add_row(beat_of(CMD_ENTRY, 16'hFFFF, 16'd0, 16'd1, '0, 1, 0, 0), 0, 16'd0, 0);
    add_row(beat_of(CMD_ENTRY, 16'hFFFF, 16'd0, 16'h8000, LIMIT_MAX, 0, 0, 0), 0, 16'd0, 0);
    add_row(beat_of(CMD_ENTRY, 16'hFFFF, 16'd0, 16'd5, LIMIT_MAX, 0, 1, 0), 0, 16'd0, 0);
    // A column that scores its own row, interrupted by an ignored command.
    add_row(beat_of(CMD_SET_KEEP, 16'd7, 16'd0, 16'd0, '0, 0, 0, 1), 0, 16'd0, 0);
    add_row(beat_of(CMD_ENTRY, 16'd7, 16'd7, 16'h4000, LIMIT_MAX, 1, 0, 0), 0, 16'd0, 0);
    add_row(beat_of(CMD_UNUSED, 16'd7, 16'd7, 16'h8000, '0, 1, 1, 1), 0, 16'd0, 0);
    add_row(beat_of(CMD_ENTRY, 16'd7, 16'd0, 16'hC000, ONE_Q30 >> 1, 0, 1, 0), 0, 16'd0, 0);
    // Entry without a first mark after a report, on the edge of the strict compare.
    add_row(beat_of(CMD_ENTRY, 16'd7, 16'd0, 16'h4000, ONE_Q30 >> 2, 0, 1, 0), 0, 16'd0, 0);
    add_row(beat_of(CMD_ENTRY, 16'd0, 16'd0, 16'hFFFF, '0, 1, 1, 0), 0, 16'd0, 0);
    add_row(beat_of(CMD_SET_KEEP, 16'hFFFF, 16'd0, 16'd0, '0, 0, 0, 0), 0, 16'd0, 0);
    add_row(beat_of(CMD_EMPTY, 16'hFFFF, 16'd0, 16'd0, '0, 0, 0, 0), 1, 16'hFFFF, 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].decision);

    while (items_sent < ITEM_TARGET) begin
      // Back-pressure: a long hold-off on the result side, then a full drain.
      if (!hold_done && items_sent >= 300) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      if (!drain_done && items_sent >= 450) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (decisions_due.size() != 0) @(posedge clk_i);
        drain_done = 1'b1;
      end
      idle_en = !(items_sent >= 550 && items_sent < 700);

      case ($urandom_range(0, 19))
        0, 1, 2: begin
          repeat ($urandom_range(1, 4)) begin
            beat = noise_beat();
            beat.cmd = CMD_SET_KEEP;
            beat.column_index = pick_index();
            beat.keep_value = ($urandom_range(0, 3) != 0);
            send_beat(beat, 0, none);
          end
        end
        3, 4: begin
          beat = noise_beat();
          beat.cmd = CMD_EMPTY;
          beat.column_index = pick_index();
          send_beat(beat, 0, none);
        end
        5: begin
          beat = noise_beat();
          if ($urandom_range(0, 1)) beat.cmd = CMD_UNUSED;
          send_beat(beat, 0, none);
        end
        default: begin
          // A well-formed column, now and then missing its first or last mark.
          col        = pick_index();
          limit      = pick_limit();
          n_entries  = $urandom_range(1, 6);
          drop_first = ($urandom_range(0, 9) == 0);
          drop_last  = ($urandom_range(0, 9) == 0);
          for (int k = 0; k < n_entries; k++) begin
            beat = noise_beat();
            beat.cmd             = CMD_ENTRY;
            beat.column_index    = col;
            beat.row_index       = pick_index();
            beat.corr_value      = pick_corr();
            beat.score_limit     = limit;
            beat.first_of_column = (k == 0) && !drop_first;
            beat.last_of_column  = (k == n_entries - 1) && !drop_last;
            send_beat(beat, 0, none);
          end
        end
      endcase
    end

    in_valid_i <= 1'b0;
    idle_en = 1'b1;
    while (decisions_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && decisions_due.size() == 0)
      $display("ld_score_greedy_pruner_top_test: clean");
    else
      $display("ld_score_greedy_pruner_top_test: errors");
    $finish;
  end

endmodule
